>>> hdl/sensor_sample_fifo_register_port_macros.svh
// Assertion macros for the sensor register port.
// Used by the top level; expects clk and rst_n in scope at the point of use.
`ifndef SENSOR_SAMPLE_FIFO_REGISTER_PORT_MACROS_SVH
`define SENSOR_SAMPLE_FIFO_REGISTER_PORT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SSPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SSPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sspr_pkg.sv
// Shared types, constants and helper functions for the sensor register port.
// No dependencies; compiled first.
package sspr_pkg;

  localparam int FIFO_DEPTH = 32;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int SAMPLE_W   = 24;
  localparam int ENTRY_W    = 2 * SAMPLE_W;
  localparam int BYTE_W     = 8;
  localparam int POS_W      = 3;
  localparam int RF_AW      = 8;
  localparam int RF_DEPTH   = 1 << RF_AW;

  localparam logic [POS_W-1:0] BYTES_PER_ENTRY = POS_W'(6);

  // register map
  localparam logic [RF_AW-1:0] REG_WR_PTR   = 8'h04;
  localparam logic [RF_AW-1:0] REG_OVF      = 8'h05;
  localparam logic [RF_AW-1:0] REG_RD_PTR   = 8'h06;
  localparam logic [RF_AW-1:0] REG_DATA     = 8'h07;
  localparam logic [RF_AW-1:0] REG_FIFO_CFG = 8'h08;
  localparam logic [RF_AW-1:0] REG_MODE_CFG = 8'h09;
  localparam logic [RF_AW-1:0] REG_SPO2_CFG = 8'h0A;
  localparam logic [RF_AW-1:0] REG_ID       = 8'hFF;

  localparam logic [BYTE_W-1:0] PART_ID      = 8'h15;
  localparam logic [BYTE_W-1:0] FIFO_CFG_RST = 8'h0F;
  localparam logic [BYTE_W-1:0] MODE_CFG_RST = 8'h03;
  localparam logic [BYTE_W-1:0] SPO2_CFG_RST = 8'h27;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_STOP   = 2'd3
  } func_t;

  typedef struct packed {
    logic              en;
    logic [RF_AW-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } rf_wr_t;

  typedef struct packed {
    logic               en;
    logic [PTR_W-1:0]   addr;
    logic [ENTRY_W-1:0] data;
  } ss_wr_t;

  function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  // depth is a power of two, so a byte modulo depth is its low bits
  function automatic logic [PTR_W-1:0] mod_depth(input logic [BYTE_W-1:0] b);
    return b[PTR_W-1:0];
  endfunction

  function automatic logic [BYTE_W-1:0] rf_default(input logic [RF_AW-1:0] a);
    logic [BYTE_W-1:0] d;
    case (a)
      REG_FIFO_CFG: d = FIFO_CFG_RST;
      REG_MODE_CFG: d = MODE_CFG_RST;
      REG_SPO2_CFG: d = SPO2_CFG_RST;
      REG_ID:       d = PART_ID;
      default:      d = '0;
    endcase
    return d;
  endfunction

endpackage

>>> hdl/sspr_if.sv
// Valid/ready channel interfaces for the sensor register port.
// Depends on sspr_pkg.
interface sspr_in_if;
  import sspr_pkg::*;
  logic                valid;
  logic                ready;
  func_t               func;
  logic [SAMPLE_W-1:0] red_level;
  logic [SAMPLE_W-1:0] ir_level;
  logic                finger_present;
  logic [BYTE_W-1:0]   write_byte;

  modport source (output valid, func, red_level, ir_level, finger_present, write_byte,
                  input ready);
  modport sink   (input valid, func, red_level, ir_level, finger_present, write_byte,
                  output ready);
endinterface

interface sspr_out_if;
  import sspr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_byte;
  logic              read_valid;

  modport source (output valid, read_byte, read_valid, input ready);
  modport sink   (input valid, read_byte, read_valid, output ready);
endinterface

>>> hdl/sspr_regfile.sv
// 256 x 8 register file: one write port, one registered read port.
// Per-entry valid bits give reset values without a clearing pass. Depends on sspr_pkg.
module sspr_regfile (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sspr_pkg::rf_wr_t              wr,
  input  logic [sspr_pkg::RF_AW-1:0]    rd_addr,
  output logic [sspr_pkg::BYTE_W-1:0]   rd_data
);
  import sspr_pkg::*;

  logic [BYTE_W-1:0] mem [RF_DEPTH];
  logic [RF_DEPTH-1:0] valid_r;
  logic [RF_AW-1:0]    addr_r;
  logic [BYTE_W-1:0]   data_r;

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
    // write-through keeps a same-edge write visible
    data_r <= (wr.en && (wr.addr == rd_addr)) ? wr.data : mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      addr_r  <= '0;
    end else begin
      if (wr.en) valid_r[wr.addr] <= 1'b1;
      addr_r <= rd_addr;
    end
  end

  assign rd_data = valid_r[addr_r] ? data_r : rf_default(addr_r);

endmodule

>>> hdl/sspr_sample_store.sv
// Sample FIFO storage: FIFO_DEPTH entries of red/ir, one write, one byte read.
// Entries never written read as zero. Depends on sspr_pkg.
module sspr_sample_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sspr_pkg::ss_wr_t              wr,
  input  logic [sspr_pkg::PTR_W-1:0]    rd_ptr,
  input  logic [sspr_pkg::POS_W-1:0]    pos,
  output logic [sspr_pkg::BYTE_W-1:0]   rd_byte
);
  import sspr_pkg::*;

  logic [ENTRY_W-1:0]    store_r [FIFO_DEPTH];
  logic [FIFO_DEPTH-1:0] valid_r;
  logic [ENTRY_W-1:0]    entry;

  always_ff @(posedge clk) begin
    if (wr.en) store_r[wr.addr] <= wr.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  always_comb begin
    entry = valid_r[rd_ptr] ? store_r[rd_ptr] : '0;
    // red high byte first
    case (pos)
      3'd0:    rd_byte = entry[47:40];
      3'd1:    rd_byte = entry[39:32];
      3'd2:    rd_byte = entry[31:24];
      3'd3:    rd_byte = entry[23:16];
      3'd4:    rd_byte = entry[15:8];
      3'd5:    rd_byte = entry[7:0];
      default: rd_byte = '0;
    endcase
  end

endmodule

>>> hdl/sensor_sample_fifo_register_port.sv
// Optical pulse sensor register port with a 32-entry red/ir sample FIFO. Each item is
// a new sample, a bus write byte, a bus read byte or a bus stop, and yields exactly one
// result: the read byte with read_valid set for a bus read, zero otherwise. Items pass
// an input register, one step of update logic and a result register, in that order,
// and one item is taken every cycle while the result register is free or draining.
// The pace is set by the register file read port: its address is the next register
// pointer, registered before the item that uses it. Reset values of the register
// file and sample store come from valid bits cleared at reset, so the block
// accepts items as soon as reset is released, with no clearing pass.
// Depends on sspr_pkg, sspr_if, sspr_regfile, sspr_sample_store and the macros header.
`include "sensor_sample_fifo_register_port_macros.svh"

module sensor_sample_fifo_register_port (
  input logic        clk,
  input logic        rst_n,
  sspr_in_if.sink    in_chan,
  sspr_out_if.source out_chan
);
  import sspr_pkg::*;

  // input register
  logic                in_vld_r;
  func_t               in_func_r;
  logic [SAMPLE_W-1:0] in_red_r;
  logic [SAMPLE_W-1:0] in_ir_r;
  logic                in_fp_r;
  logic [BYTE_W-1:0]   in_wb_r;

  // result register
  logic              out_vld_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_rv_r;

  // architectural state
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [RF_AW-1:0] reg_ptr_r, reg_ptr_nxt;
  logic             sel_r, sel_nxt;

  logic              fire;
  rf_wr_t            rf_wr;
  ss_wr_t            ss_wr;
  logic [BYTE_W-1:0] rf_rdata;
  logic [BYTE_W-1:0] ss_byte;
  logic [POS_W-1:0]  pos_sel;
  logic [POS_W-1:0]  pos_inc;
  logic [PTR_W-1:0]  wr_adv;
  logic [BYTE_W-1:0] res_byte;
  logic              res_valid;

  // item in the input register moves on when the result slot is free or draining
  assign fire          = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_func_r <= in_chan.func;
      in_red_r  <= in_chan.red_level;
      in_ir_r   <= in_chan.ir_level;
      in_fp_r   <= in_chan.finger_present;
      in_wb_r   <= in_chan.write_byte;
    end
  end

  // a stale byte position beyond the entry restarts at the red high byte
  assign pos_sel = (pos_r >= BYTES_PER_ENTRY) ? '0 : pos_r;
  assign pos_inc = POS_W'(pos_sel + 1'b1);
  assign wr_adv  = wrap_next(wr_ptr_r);

  always_comb begin
    wr_ptr_nxt  = wr_ptr_r;
    rd_ptr_nxt  = rd_ptr_r;
    pos_nxt     = pos_r;
    reg_ptr_nxt = reg_ptr_r;
    sel_nxt     = sel_r;
    rf_wr       = '0;
    ss_wr       = '0;
    res_byte    = '0;
    res_valid   = 1'b0;
    if (fire) begin
      case (in_func_r)
        FUNC_SAMPLE: begin
          ss_wr.en   = 1'b1;
          ss_wr.addr = wr_ptr_r;
          ss_wr.data = {in_red_r, in_ir_r};
          // with contact, a full FIFO drops its oldest entry
          if (in_fp_r && (wr_adv == rd_ptr_r)) rd_ptr_nxt = wrap_next(rd_ptr_r);
          wr_ptr_nxt = wr_adv;
        end
        FUNC_WRITE: begin
          if (!sel_r) begin
            // first byte after a stop selects the register
            reg_ptr_nxt = in_wb_r;
            sel_nxt     = 1'b1;
          end else begin
            rf_wr.en   = 1'b1;
            rf_wr.addr = reg_ptr_r;
            rf_wr.data = (reg_ptr_r == REG_OVF) ? '0 : in_wb_r;
            if (reg_ptr_r == REG_WR_PTR) wr_ptr_nxt = mod_depth(in_wb_r);
            if (reg_ptr_r == REG_RD_PTR) rd_ptr_nxt = mod_depth(in_wb_r);
            reg_ptr_nxt = RF_AW'(reg_ptr_r + 1'b1);
          end
        end
        FUNC_READ: begin
          res_valid = 1'b1;
          case (reg_ptr_r)
            REG_ID:     res_byte = PART_ID;
            REG_WR_PTR: res_byte = BYTE_W'(wr_ptr_r);
            REG_RD_PTR: res_byte = BYTE_W'(rd_ptr_r);
            REG_DATA: begin
              res_byte = ss_byte;
              // after the last byte of an entry, step to the next entry
              if (pos_inc == BYTES_PER_ENTRY) begin
                pos_nxt    = '0;
                rd_ptr_nxt = wrap_next(rd_ptr_r);
              end else begin
                pos_nxt = pos_inc;
              end
            end
            default:    res_byte = rf_rdata;
          endcase
        end
        FUNC_STOP: sel_nxt = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      pos_r     <= '0;
      reg_ptr_r <= '0;
      sel_r     <= 1'b0;
    end else begin
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      pos_r     <= pos_nxt;
      reg_ptr_r <= reg_ptr_nxt;
      sel_r     <= sel_nxt;
    end
  end

  // result register: holds while the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r <= res_byte;
      out_rv_r   <= res_valid;
    end
  end

  assign out_chan.valid      = out_vld_r;
  assign out_chan.read_byte  = out_byte_r;
  assign out_chan.read_valid = out_rv_r;

  // register file read is addressed with the pointer the next item will see
  sspr_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (rf_wr),
    .rd_addr (reg_ptr_nxt),
    .rd_data (rf_rdata)
  );

  sspr_sample_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (ss_wr),
    .rd_ptr  (rd_ptr_r),
    .pos     (pos_sel),
    .rd_byte (ss_byte)
  );

  // checks
  `SSPR_ASSERT_NOW(a_pos_range, 1'b1, pos_r < BYTES_PER_ENTRY, "byte position beyond entry")
  `SSPR_ASSERT_NEXT(a_out_hold, out_vld_r && !out_chan.ready, out_vld_r, "result lost in stall")
  `SSPR_ASSERT_NEXT(a_stop_clears, fire && (in_func_r == FUNC_STOP), !sel_r, "stop kept select")
  `SSPR_ASSERT_NEXT(a_nonread_zero, fire && (in_func_r != FUNC_READ), !out_rv_r, "non-read flagged")

endmodule
